### src/tth_pkg.sv
// Shared constants, codes and hash tables for the two-table hash core.
`timescale 1ns / 1ps

package tth_pkg;

  // Table geometry
  localparam int SLOTS = 11;
  localparam int IDX_W = $clog2(SLOTS);

  // Beat fields
  localparam int OP_W        = 2;
  localparam int KEY_W       = 31;
  localparam int SLOT_W      = 4;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 8;

  // Second hash works on the decimal digit behind the 0.9 factor
  localparam int DEC = 10;
  localparam int DIG_W = 4;

  // Byte folding: key mod m = sum(byte_j * (256^j mod m)) mod m
  localparam int PSUM_W   = 16;
  localparam int RECIP_SH = 24;
  localparam int PROD_W   = PSUM_W + RECIP_SH;

  localparam int W1_B1 = 256 % SLOTS;
  localparam int W1_B2 = 65536 % SLOTS;
  localparam int W1_B3 = 16777216 % SLOTS;
  localparam int WD_B1 = 256 % DEC;
  localparam int WD_B2 = 65536 % DEC;
  localparam int WD_B3 = 16777216 % DEC;

  // ceil(2^RECIP_SH / m); exact quotient for any folded sum below 2^PSUM_W
  localparam int RECIP_ONE = ((1 << RECIP_SH) + SLOTS - 1) / SLOTS;
  localparam int RECIP_DEC = ((1 << RECIP_SH) + DEC - 1) / DEC;

  // Table-two index by key mod 10: floor(SLOTS * ((9*d) mod 10) / 10)
  localparam logic [IDX_W-1:0] H2_BY_DIGIT [DEC] = '{
    IDX_W'((SLOTS * 0) / DEC),
    IDX_W'((SLOTS * 9) / DEC),
    IDX_W'((SLOTS * 8) / DEC),
    IDX_W'((SLOTS * 7) / DEC),
    IDX_W'((SLOTS * 6) / DEC),
    IDX_W'((SLOTS * 5) / DEC),
    IDX_W'((SLOTS * 4) / DEC),
    IDX_W'((SLOTS * 3) / DEC),
    IDX_W'((SLOTS * 2) / DEC),
    IDX_W'((SLOTS * 1) / DEC)
  };

  // Request codes
  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LOOKUP = 2'd2
  } op_t;

  // Table-one slot marks
  typedef enum logic [1:0] {
    MARK_EMPTY = 2'd0,
    MARK_USED  = 2'd1,
    MARK_GONE  = 2'd2
  } mark_t;

  // One result beat
  typedef struct packed {
    logic              key_dropped;
    logic [SLOT_W-1:0] slot;
    logic              in_second_table;
    logic              ok;
  } result_t;

endpackage

### src/two_table_cuckoo_hash_core.sv
// Two-table cuckoo-style hash store: hash pipeline, flip-flop tables and result register.
`timescale 1ns / 1ps

// Each input beat is an insert, remove or lookup of one key and yields exactly one result
// beat. Requests are taken one per clock while the output side is not stalled; each result
// passes through the input register, hash fold register, index register and result register.
// All table reads and writes happen in the last stage, so each request sees every earlier
// request's effect with no hazard and no bubble. Both tables are rows of flip-flops; reset
// empties them at once (marks and used bits clear), so requests are accepted from the first
// cycle after reset. A stall on out_tready backs up through the stages and drops in_tready
// only when every stage is full.

module two_table_cuckoo_hash_core
  import tth_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // input beat
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [1:0] operation, [32:2] key, [39:33] zero
  // result beat
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // [0] ok, [1] in_second_table, [5:2] slot,
                                             // [6] key_dropped, [7] zero
);

  // ---------------------------------------------------------------------------
  // Pipeline registers
  // ---------------------------------------------------------------------------
  logic              s1_valid_r;
  logic [OP_W-1:0]   s1_op_r;
  logic [KEY_W-1:0]  s1_key_r;

  logic              s2_valid_r;
  logic [OP_W-1:0]   s2_op_r;
  logic [KEY_W-1:0]  s2_key_r;
  logic [PSUM_W-1:0] s2_p1_r;
  logic [PSUM_W-1:0] s2_pd_r;

  logic              s3_valid_r;
  logic [OP_W-1:0]   s3_op_r;
  logic [KEY_W-1:0]  s3_key_r;
  logic [IDX_W-1:0]  s3_a_r;
  logic [IDX_W-1:0]  s3_b_r;

  logic              out_valid_r;
  result_t           out_res_r;

  // Tables
  logic [KEY_W-1:0]  first_keys_r  [SLOTS];
  logic [IDX_W-1:0]  first_h2_r    [SLOTS];
  logic [1:0]        first_marks_r [SLOTS];
  logic [KEY_W-1:0]  second_keys_r [SLOTS];
  logic [SLOTS-1:0]  second_used_r;

  // Handshake chain
  logic out_free, rdy3, rdy2, go3;

  assign out_free  = !out_valid_r || out_tready;
  assign go3       = s3_valid_r && out_free;
  assign rdy3      = !s3_valid_r || out_free;
  assign rdy2      = !s2_valid_r || rdy3;
  assign in_tready = !s1_valid_r || rdy2;

  // ---------------------------------------------------------------------------
  // Stage 1 -> 2: fold key bytes against byte weights for both moduli
  // ---------------------------------------------------------------------------
  logic [PSUM_W-1:0] p1_nxt, pd_nxt;

  always_comb begin
    p1_nxt = PSUM_W'(s1_key_r[7:0])
           + PSUM_W'(s1_key_r[15:8])  * PSUM_W'(W1_B1)
           + PSUM_W'(s1_key_r[23:16]) * PSUM_W'(W1_B2)
           + PSUM_W'(s1_key_r[30:24]) * PSUM_W'(W1_B3);
    pd_nxt = PSUM_W'(s1_key_r[7:0])
           + PSUM_W'(s1_key_r[15:8])  * PSUM_W'(WD_B1)
           + PSUM_W'(s1_key_r[23:16]) * PSUM_W'(WD_B2)
           + PSUM_W'(s1_key_r[30:24]) * PSUM_W'(WD_B3);
  end

  // ---------------------------------------------------------------------------
  // Stage 2 -> 3: reduce folded sums by reciprocal multiply, map digit to index
  // ---------------------------------------------------------------------------
  logic [PROD_W-1:0] prod1, prodd;
  logic [PSUM_W-1:0] q1, qd, r1, rd;
  logic [DIG_W-1:0]  digit;
  logic [IDX_W-1:0]  a_nxt, b_nxt;

  always_comb begin
    prod1 = PROD_W'(s2_p1_r) * PROD_W'(RECIP_ONE);
    prodd = PROD_W'(s2_pd_r) * PROD_W'(RECIP_DEC);
    q1    = prod1[PROD_W-1:RECIP_SH];
    qd    = prodd[PROD_W-1:RECIP_SH];
    r1    = s2_p1_r - PSUM_W'(q1 * PSUM_W'(SLOTS));
    rd    = s2_pd_r - PSUM_W'(qd * PSUM_W'(DEC));
    digit = rd[DIG_W-1:0];
    a_nxt = r1[IDX_W-1:0];
    b_nxt = H2_BY_DIGIT[digit];
  end

  // ---------------------------------------------------------------------------
  // Stage 3: per-slot match cells, one-hot selection, table decisions
  // ---------------------------------------------------------------------------
  logic [SLOTS-1:0] sel_a, sel_b, sel_c;
  logic [SLOTS-1:0] eq_one, eq_two;
  logic [1:0]       mark_a;
  logic [KEY_W-1:0] key_old;
  logic [IDX_W-1:0] c_idx;
  logic             hit_one, hit_two, used_c;
  logic             wr_first, gone_first, wr_second, clr_second;
  result_t          res_nxt;

  // Slot cells: decode and compare each entry in its own place
  always_comb begin
    mark_a  = '0;
    key_old = '0;
    c_idx   = '0;
    for (int i = 0; i < SLOTS; i++) begin
      sel_a[i]  = (s3_a_r == IDX_W'(i));
      sel_b[i]  = (s3_b_r == IDX_W'(i));
      eq_one[i] = (first_keys_r[i] == s3_key_r);
      eq_two[i] = (second_keys_r[i] == s3_key_r);
      mark_a    = mark_a  | (first_marks_r[i] & {2{sel_a[i]}});
      key_old   = key_old | (first_keys_r[i]  & {KEY_W{sel_a[i]}});
      c_idx     = c_idx   | (first_h2_r[i]    & {IDX_W{sel_a[i]}});
    end
    for (int i = 0; i < SLOTS; i++) begin
      sel_c[i] = (c_idx == IDX_W'(i));
    end
    hit_one = (mark_a == MARK_USED) && |(sel_a & eq_one);
    hit_two = |(sel_b & second_used_r & eq_two);
    used_c  = |(sel_c & second_used_r);
  end

  // Request decisions
  always_comb begin
    res_nxt    = '0;
    wr_first   = 1'b0;
    gone_first = 1'b0;
    wr_second  = 1'b0;
    clr_second = 1'b0;
    case (s3_op_r)
      OP_INSERT: begin
        wr_first    = 1'b1;
        res_nxt.ok  = 1'b1;
        if (mark_a == MARK_USED) begin
          wr_second           = !used_c;
          res_nxt.key_dropped = used_c;
        end
      end
      OP_REMOVE: begin
        // table two first, then table one
        if (hit_two) begin
          clr_second = 1'b1;
          res_nxt.ok = 1'b1;
        end else if (hit_one) begin
          gone_first = 1'b1;
          res_nxt.ok = 1'b1;
        end
      end
      OP_LOOKUP: begin
        // an empty table-one slot ends the search
        if (mark_a != MARK_EMPTY) begin
          if (hit_one) begin
            res_nxt.ok   = 1'b1;
            res_nxt.slot = SLOT_W'(s3_a_r);
          end else if (hit_two) begin
            res_nxt.ok              = 1'b1;
            res_nxt.in_second_table = 1'b1;
            res_nxt.slot            = SLOT_W'(s3_b_r);
          end
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Control registers: stage valids, output valid, marks and used bits
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      s2_valid_r    <= 1'b0;
      s3_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      second_used_r <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        first_marks_r[i] <= MARK_EMPTY;
      end
    end else begin
      if (in_tready) s1_valid_r <= in_tvalid;
      if (rdy2)      s2_valid_r <= s1_valid_r;
      if (rdy3)      s3_valid_r <= s2_valid_r;
      if (out_free)  out_valid_r <= s3_valid_r;
      if (go3) begin
        for (int i = 0; i < SLOTS; i++) begin
          if (sel_a[i] && wr_first)   first_marks_r[i] <= MARK_USED;
          if (sel_a[i] && gone_first) first_marks_r[i] <= MARK_GONE;
          if (sel_c[i] && wr_second)  second_used_r[i] <= 1'b1;
          if (sel_b[i] && clr_second) second_used_r[i] <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Payload registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_op_r  <= in_tdata[OP_W-1:0];
      s1_key_r <= in_tdata[OP_W +: KEY_W];
    end
    if (rdy2 && s1_valid_r) begin
      s2_op_r  <= s1_op_r;
      s2_key_r <= s1_key_r;
      s2_p1_r  <= p1_nxt;
      s2_pd_r  <= pd_nxt;
    end
    if (rdy3 && s2_valid_r) begin
      s3_op_r  <= s2_op_r;
      s3_key_r <= s2_key_r;
      s3_a_r   <= a_nxt;
      s3_b_r   <= b_nxt;
    end
    if (go3) begin
      out_res_r <= res_nxt;
      for (int i = 0; i < SLOTS; i++) begin
        // the new key's table-two index is kept for a later move
        if (sel_a[i] && wr_first) begin
          first_keys_r[i] <= s3_key_r;
          first_h2_r[i]   <= s3_b_r;
        end
        if (sel_c[i] && wr_second) second_keys_r[i] <= key_old;
      end
    end
  end

  // Result beat
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_res_r.key_dropped, out_res_r.slot,
                       out_res_r.in_second_table, out_res_r.ok};

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_insert_marks_used: assert property (@(posedge clk) disable iff (!rst_n)
    go3 && s3_op_r == OP_INSERT |=> first_marks_r[$past(s3_a_r)] == MARK_USED)
    else $error("insert did not leave its table-one slot in use");

  a_remove_two_clears: assert property (@(posedge clk) disable iff (!rst_n)
    go3 && clr_second |=> !second_used_r[$past(s3_b_r)])
    else $error("table-two removal left the slot in use");

  a_second_needs_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_res_r.in_second_table || out_res_r.key_dropped) |-> out_res_r.ok)
    else $error("table-two or drop flag on a failed request");

  a_out_from_stage3: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(go3))
    else $error("result beat appeared without a stage-three transfer");

endmodule

### dv/tb_two_table_cuckoo_hash_core.sv
// Self-checking testbench for the two-table cuckoo hash core: directed, random and stall tests.
`timescale 1ns / 1ps

module tb_two_table_cuckoo_hash_core;
  import tth_pkg::*;

  // Opcode outside the defined set; the core must leave the tables alone
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // Receiver stall patterns
  localparam int STALL_NONE     = 0;
  localparam int STALL_RANDOM   = 1;
  localparam int STALL_PERIODIC = 2;
  localparam int STALL_HEAVY    = 3;

  localparam int KEY_POOL_SIZE = 48;
  localparam int RANDOM_ITEMS  = 2000;
  localparam int PAD_W         = IN_TDATA_W - KEY_W - OP_W;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  // Shadow copy of both tables
  logic [KEY_W-1:0] t1_keys  [SLOTS];
  mark_t            t1_marks [SLOTS];
  logic [KEY_W-1:0] t2_keys  [SLOTS];
  logic             t2_used  [SLOTS];

  result_t          pending_results [$];
  logic [KEY_W-1:0] key_pool [KEY_POOL_SIZE];
  int               error_count = 0;
  int               stall_mode  = STALL_NONE;
  int               hold_cycles = 0;
  int               ready_phase = 0;

  two_table_cuckoo_hash_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #10 clk = ~clk;

  // Run limit
  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Hashes
  function automatic int unsigned slot_one(input logic [KEY_W-1:0] key);
    return key % SLOTS;
  endfunction

  function automatic int unsigned slot_two(input logic [KEY_W-1:0] key);
    longint unsigned tenth;
    tenth = (longint'(key) * 9) % 10;
    return 32'((SLOTS * tenth) / 10);
  endfunction

  // Apply one request to the shadow tables and return its result beat
  function automatic result_t apply_request(input logic [OP_W-1:0] op,
                                            input logic [KEY_W-1:0] key);
    int unsigned      a;
    int unsigned      b;
    int unsigned      c;
    logic [KEY_W-1:0] old_key;
    result_t          r;
    r = '0;
    a = slot_one(key);
    b = slot_two(key);
    case (op)
      OP_INSERT: begin
        // live occupant is kicked to table two, or lost if that slot is taken
        if (t1_marks[a] == MARK_USED) begin
          old_key = t1_keys[a];
          c = slot_two(old_key);
          if (!t2_used[c]) begin
            t2_keys[c] = old_key;
            t2_used[c] = 1'b1;
          end else begin
            r.key_dropped = 1'b1;
          end
        end
        t1_keys[a]  = key;
        t1_marks[a] = MARK_USED;
        r.ok = 1'b1;
      end
      OP_REMOVE: begin
        if (t2_used[b] && t2_keys[b] == key) begin
          t2_used[b] = 1'b0;
          t2_keys[b] = '0;
          r.ok = 1'b1;
        end else if (t1_marks[a] == MARK_USED && t1_keys[a] == key) begin
          t1_marks[a] = MARK_GONE;
          t1_keys[a]  = '0;
          r.ok = 1'b1;
        end
      end
      OP_LOOKUP: begin
        // an empty table-one slot ends the search
        if (t1_marks[a] != MARK_EMPTY) begin
          if (t1_marks[a] == MARK_USED && t1_keys[a] == key) begin
            r.ok   = 1'b1;
            r.slot = SLOT_W'(a);
          end else if (t2_used[b] && t2_keys[b] == key) begin
            r.ok              = 1'b1;
            r.in_second_table = 1'b1;
            r.slot            = SLOT_W'(b);
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Send one request beat; valid stays high for a following beat
  task automatic send_beat(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {{PAD_W{1'b0}}, key, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(apply_request(op, key));
  endtask

  // Drop valid; n (n >= 1) sets the length of the idle gap
  task automatic idle_gap(input int n);
    @(negedge clk);
    in_tvalid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    int unsigned      sel;
    logic [KEY_W-1:0] k;
    sel = $urandom_range(0, 99);
    if (sel < 60) begin
      k = key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
    end else if (sel < 80) begin
      k = KEY_W'($urandom_range(1, 120));
    end else begin
      k = KEY_W'($urandom);
      if (k == '0) k = 1;
    end
    return k;
  endfunction

  function automatic logic [OP_W-1:0] pick_op();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 40) return OP_INSERT;
    if (sel < 65) return OP_REMOVE;
    if (sel < 98) return OP_LOOKUP;
    return OP_UNUSED;
  endfunction

  // Receiver: long hold-off when requested, otherwise the selected pattern
  always @(negedge clk) begin
    ready_phase = ready_phase + 1;
    if (hold_cycles > 0) begin
      hold_cycles = hold_cycles - 1;
      out_tready <= 1'b0;
    end else begin
      case (stall_mode)
        STALL_RANDOM:   out_tready <= ($urandom_range(0, 3) != 0);
        STALL_PERIODIC: out_tready <= ((ready_phase % 7) < 4);
        STALL_HEAVY:    out_tready <= ($urandom_range(0, 3) == 0);
        default:        out_tready <= 1'b1;
      endcase
    end
  end

  // Result checker
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = result_t'(out_tdata[$bits(result_t)-1:0]);
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual %h", $time, out_tdata);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.ok !== want.ok) begin
          $display("%0t: ok mismatch, expected %0d actual %0d", $time, want.ok, got.ok);
          error_count++;
        end
        if (got.in_second_table !== want.in_second_table) begin
          $display("%0t: in_second_table mismatch, expected %0d actual %0d",
                   $time, want.in_second_table, got.in_second_table);
          error_count++;
        end
        if (got.slot !== want.slot) begin
          $display("%0t: slot mismatch, expected %0d actual %0d", $time, want.slot, got.slot);
          error_count++;
        end
        if (got.key_dropped !== want.key_dropped) begin
          $display("%0t: key_dropped mismatch, expected %0d actual %0d",
                   $time, want.key_dropped, got.key_dropped);
          error_count++;
        end
      end
    end
  end

  // Empty table, extreme keys, collisions, drops, deleted marks, key zero, unused opcode
  task automatic test_directed();
    send_beat(OP_LOOKUP, 31'd5);           // empty slot: miss without table two
    send_beat(OP_INSERT, 31'd1);
    send_beat(OP_INSERT, 31'h7FFF_FFFF);
    send_beat(OP_LOOKUP, 31'd1);
    send_beat(OP_LOOKUP, 31'h7FFF_FFFF);
    send_beat(OP_INSERT, 31'd12);          // kicks 7FFF_FFFF into table two
    send_beat(OP_LOOKUP, 31'd1);
    send_beat(OP_LOOKUP, 31'd12);
    send_beat(OP_INSERT, 31'd23);          // kicks 12 into table two
    send_beat(OP_INSERT, 31'd23);          // duplicate insert moves the old copy
    send_beat(OP_INSERT, 31'd34);          // table-two slot taken: occupant dropped
    send_beat(OP_REMOVE, 31'd23);          // found in table two first
    send_beat(OP_REMOVE, 31'd34);          // leaves a deleted mark
    send_beat(OP_LOOKUP, 31'd1);           // deleted mark: table two still searched
    send_beat(OP_LOOKUP, 31'd12);
    send_beat(OP_INSERT, 31'd45);          // deleted slot reused, no move
    send_beat(OP_REMOVE, 31'd100);         // miss
    send_beat(OP_INSERT, 31'd0);           // key zero is an ordinary key
    send_beat(OP_LOOKUP, 31'd0);
    send_beat(OP_UNUSED, 31'h5555_5555);
    send_beat(OP_UNUSED, 31'h2AAA_AAAA);
    send_beat(OP_REMOVE, 31'h7FFF_FFFF);
    send_beat(OP_LOOKUP, 31'h7FFF_FFFF);
    idle_gap(1);
    wait_drained();
  endtask

  // Receiver holds off long enough that the pipeline fills and stalls the input
  task automatic test_fill_stall();
    stall_mode  = STALL_NONE;
    hold_cycles = 60;
    repeat (24) send_beat(pick_op(), pick_key());
    idle_gap(1);
    wait_drained();
  endtask

  // Sender pauses mid-stream until every result is back
  task automatic test_drain_pause();
    stall_mode = STALL_RANDOM;
    repeat (16) send_beat(pick_op(), pick_key());
    idle_gap(1);
    wait_drained();
    repeat (16) send_beat(pick_op(), pick_key());
    idle_gap(1);
    wait_drained();
  endtask

  // Random traffic in bursts, rotating receiver patterns
  task automatic test_random_traffic();
    int burst_left;
    burst_left = 0;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 250 == 0) stall_mode = (i / 250) % 4;
      if (burst_left == 0) begin
        // some long bursts so stretches pass with no sender idling
        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                 : $urandom_range(1, 20);
        idle_gap($urandom_range(1, 8));
      end
      send_beat(pick_op(), pick_key());
      burst_left--;
    end
    idle_gap(1);
  endtask

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      t1_keys[i]  = '0;
      t1_marks[i] = MARK_EMPTY;
      t2_keys[i]  = '0;
      t2_used[i]  = 1'b0;
    end
    // Pool mixes colliding small keys with wide random ones
    for (int i = 0; i < KEY_POOL_SIZE; i++) begin
      if (i < KEY_POOL_SIZE / 2) begin
        key_pool[i] = KEY_W'(1 + i * SLOTS + $urandom_range(0, 2));
      end else begin
        key_pool[i] = KEY_W'($urandom) | 31'd1;
      end
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_fill_stall();
    test_drain_pause();
    test_random_traffic();

    wait_drained();
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
